@@ rtl/acu_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// acu_pkg
// Types and fixed widths shared by the interval update block and its units.
// ----------------------------------------------------------------------------
package acu_pkg;

  localparam int SL_W       = 16;  // sym_low width
  localparam int TW         = 17;  // sym_high / total width
  localparam int MAX_EVENTS = 32;
  localparam int EV_CW      = 6;   // holds 0..MAX_EVENTS

  typedef struct packed {
    logic [SL_W-1:0] sym_low;
    logic [TW-1:0]   sym_high;
    logic [TW-1:0]   total;
  } acu_in_t;

  typedef struct packed {
    logic kind;
    logic bit_res;
    logic last;
  } acu_out_t;

  // one renormalization move as seen by the sequencer
  typedef struct packed {
    logic hit;
    logic kind;
    logic bit_res;
  } acu_ev_t;

endpackage

`default_nettype wire

@@ rtl/arithmetic_coder_interval_update.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// arithmetic_coder_interval_update
// Range coder interval narrowing and renormalization event stream.
// ----------------------------------------------------------------------------
// Usage:
//   in channel: one item per symbol (sym_low, sym_high, total). in_stall is
//   high from acceptance until the symbol's renormalization is finished.
//   out channel: zero or more events per symbol (kind, bit_res, last); last
//   marks the final event of a symbol, at most 32 events are sent per symbol.
//   Steps: accept, prep, scaling (two bit-serial lanes, one range bit each
//   per cycle), update, then renormalization moves one at a time until a
//   check finds no move.
//   Events go through an output register; a stall on the out channel holds
//   the renormalization sequencer at the next event until the register
//   frees. The last event may still wait while the next symbol is taken.
//   Reset (rst, synchronous) sets low to zero and high to all ones, empties
//   the output register and returns the sequencer to idle.
// ----------------------------------------------------------------------------
module arithmetic_coder_interval_update
  import acu_pkg::*;
#(
  parameter int PRECISION = 32,
  parameter int FREQ_BITS = 16
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire acu_in_t  in_item,
  output logic          out_valid,
  input  wire logic     out_stall,
  output acu_out_t      out_item
);

  localparam int QW = PRECISION + 1;
  localparam int CW = $clog2(QW + 1);
  localparam logic [31:0] TOTAL_MAX = 32'd1 << FREQ_BITS;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_SCALE,
    S_UPDATE,
    S_RENORM
  } state_t;

  state_t               state;
  logic [PRECISION-1:0] low;
  logic [PRECISION-1:0] high;
  logic [QW-1:0]        rng;
  logic [CW-1:0]        sc_cnt;
  logic [TW-1:0]        a_lo;
  logic [TW-1:0]        a_hi;
  logic [TW-1:0]        t_reg;
  logic [EV_CW-1:0]     ev_cnt;

  logic [TW-1:0]        t_cl;
  logic [TW-1:0]        hi_cl;
  logic [TW-1:0]        lo_cl;
  logic [PRECISION-1:0] high_eff;
  logic [QW-1:0]        q_lo;
  logic [QW-1:0]        q_hi;
  logic [QW-1:0]        sum_lo;
  logic [QW-1:0]        sum_hi;
  logic [PRECISION-1:0] nl;
  logic [PRECISION-1:0] nh;
  logic                 out_free;
  logic                 ev_load;
  logic                 lane_start;
  logic                 lane_step;

  acu_ev_t              ev_cur;
  acu_ev_t              ev_nx;
  logic [PRECISION-1:0] low_mv;
  logic [PRECISION-1:0] high_mv;
  logic [PRECISION-1:0] low_nx_unused;
  logic [PRECISION-1:0] high_nx_unused;

  assign in_stall   = (state != S_IDLE);
  assign out_free   = !out_valid || !out_stall;
  assign ev_load    = (state == S_RENORM) && ev_cur.hit &&
                      (ev_cnt != EV_CW'(MAX_EVENTS)) && out_free;
  assign lane_start = (state == S_PREP);
  assign lane_step  = (state == S_SCALE);

  // input clamps
  always_comb begin
    t_cl = (in_item.total == '0) ? TW'(1) : in_item.total;
    if ({15'd0, t_cl} > TOTAL_MAX) begin
      t_cl = TOTAL_MAX[TW-1:0];
    end
    hi_cl = (in_item.sym_high > t_cl) ? t_cl : in_item.sym_high;
    if (hi_cl == '0) begin
      hi_cl = TW'(1);
    end
    lo_cl = ({1'b0, in_item.sym_low} >= hi_cl) ? (hi_cl - TW'(1))
                                                : {1'b0, in_item.sym_low};
  end

  always_comb begin
    high_eff = (high < low) ? low : high;
    sum_lo   = {1'b0, low} + q_lo;
    sum_hi   = {1'b0, low} + q_hi - QW'(1);
    nl       = sum_lo[PRECISION-1:0];
    nh       = (q_hi <= q_lo) ? nl : sum_hi[PRECISION-1:0];
  end

  acu_scale_lane #(.QW(QW)) u_lane_lo (
    .clk     (clk),
    .start   (lane_start),
    .step    (lane_step),
    .rng_bit (rng[QW-1]),
    .a       (a_lo),
    .t       (t_reg),
    .q       (q_lo)
  );

  acu_scale_lane #(.QW(QW)) u_lane_hi (
    .clk     (clk),
    .start   (lane_start),
    .step    (lane_step),
    .rng_bit (rng[QW-1]),
    .a       (a_hi),
    .t       (t_reg),
    .q       (q_hi)
  );

  acu_renorm #(.PRECISION(PRECISION)) u_renorm_cur (
    .low       (low),
    .high      (high),
    .ev        (ev_cur),
    .low_next  (low_mv),
    .high_next (high_mv)
  );

  // lookahead: does the move after this one produce an event too
  acu_renorm #(.PRECISION(PRECISION)) u_renorm_nx (
    .low       (low_mv),
    .high      (high_mv),
    .ev        (ev_nx),
    .low_next  (low_nx_unused),
    .high_next (high_nx_unused)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      low       <= '0;
      high      <= '1;
      out_valid <= 1'b0;
      ev_cnt    <= '0;
      sc_cnt    <= '0;
    end else begin
      if (ev_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            a_lo  <= lo_cl;
            a_hi  <= hi_cl;
            t_reg <= t_cl;
            state <= S_PREP;
          end
        end
        S_PREP: begin
          rng    <= {1'b0, high_eff} - {1'b0, low} + QW'(1);
          sc_cnt <= CW'(QW);
          state  <= S_SCALE;
        end
        S_SCALE: begin
          rng    <= {rng[QW-2:0], 1'b0};
          sc_cnt <= sc_cnt - CW'(1);
          if (sc_cnt == CW'(1)) begin
            state <= S_UPDATE;
          end
        end
        S_UPDATE: begin
          low    <= nl;
          high   <= nh;
          ev_cnt <= '0;
          state  <= S_RENORM;
        end
        S_RENORM: begin
          if (!ev_cur.hit) begin
            state <= S_IDLE;
          end else if (ev_cnt == EV_CW'(MAX_EVENTS)) begin
            // event budget spent: keep moving without reporting
            low  <= low_mv;
            high <= high_mv;
          end else if (out_free) begin
            out_item.kind    <= ev_cur.kind;
            out_item.bit_res <= ev_cur.bit_res;
            out_item.last    <= !ev_nx.hit || (ev_cnt == EV_CW'(MAX_EVENTS - 1));
            ev_cnt           <= ev_cnt + EV_CW'(1);
            low              <= low_mv;
            high             <= high_mv;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // an event is only loaded by the renormalization sequencer
  a_out_src : assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_RENORM))
    else $error("event loaded outside renormalization");

  // the kept interval never inverts
  a_order : assert property (@(posedge clk) disable iff (rst)
    high >= low)
    else $error("interval high below low");

  // event count stays within budget
  a_cnt : assert property (@(posedge clk) disable iff (rst)
    ev_cnt <= EV_CW'(MAX_EVENTS))
    else $error("event count overflow");

  // a held event is not overwritten while the receiver stalls
  a_hold : assert property (@(posedge clk) disable iff (rst)
    $past(out_valid && out_stall) && !$past(rst) |-> out_valid && $stable(out_item))
    else $error("stalled event lost");

endmodule

`default_nettype wire

@@ rtl/acu_scale_lane.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// acu_scale_lane
// Bit-serial floor(a * range / t): one range bit per step, msb first.
// ----------------------------------------------------------------------------
module acu_scale_lane
  import acu_pkg::*;
#(
  parameter int QW = 33
) (
  input  wire logic          clk,
  input  wire logic          start,
  input  wire logic          step,
  input  wire logic          rng_bit,
  input  wire logic [TW-1:0] a,
  input  wire logic [TW-1:0] t,
  output logic      [QW-1:0] q
);

  logic [TW-1:0] rem;
  logic [TW+1:0] r2;
  logic [TW+1:0] t1;
  logic [TW+1:0] t2;
  logic          ge1;
  logic          ge2;
  logic [TW+1:0] rem_wide;
  logic [1:0]    k;

  // invariant: a * range_prefix = q * t + rem, rem < t (needs a <= t)
  always_comb begin
    r2  = {1'b0, rem, 1'b0} + (rng_bit ? {2'b00, a} : '0);
    t1  = {2'b00, t};
    t2  = {1'b0, t, 1'b0};
    ge2 = (r2 >= t2);
    ge1 = (r2 >= t1);
    if (ge2) begin
      rem_wide = r2 - t2;
      k        = 2'd2;
    end else if (ge1) begin
      rem_wide = r2 - t1;
      k        = 2'd1;
    end else begin
      rem_wide = r2;
      k        = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      q   <= '0;
    end else if (step) begin
      rem <= rem_wide[TW-1:0];
      q   <= {q[QW-2:0], 1'b0} + {{(QW-2){1'b0}}, k};
    end
  end

endmodule

`default_nettype wire

@@ rtl/acu_renorm.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// acu_renorm
// One renormalization move: detects a shift or underflow and forms the
// interval after it.
// ----------------------------------------------------------------------------
module acu_renorm
  import acu_pkg::*;
#(
  parameter int PRECISION = 32
) (
  input  wire logic [PRECISION-1:0] low,
  input  wire logic [PRECISION-1:0] high,
  output acu_ev_t                   ev,
  output logic      [PRECISION-1:0] low_next,
  output logic      [PRECISION-1:0] high_next
);

  logic shift_hit;
  logic uf_hit;

  always_comb begin
    shift_hit = (low[PRECISION-1] == high[PRECISION-1]);
    uf_hit    = !shift_hit && low[PRECISION-2] && !high[PRECISION-2];
    ev.hit     = shift_hit || uf_hit;
    ev.kind    = uf_hit;
    ev.bit_res = shift_hit && low[PRECISION-1];
    if (shift_hit) begin
      low_next  = {low[PRECISION-2:0], 1'b0};
      high_next = {high[PRECISION-2:0], 1'b1};
    end else if (uf_hit) begin
      // second bit removed, top bits stay apart
      low_next  = {~low[PRECISION-2], low[PRECISION-3:0], 1'b0};
      high_next = {1'b1, high[PRECISION-3:0], 1'b1};
    end else begin
      low_next  = low;
      high_next = high;
    end
  end

endmodule

`default_nettype wire

@@ tb/sv/interval_event_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interval_event_checker
// Watches both channels of the interval update block. Every accepted symbol
// runs through an independent integer model of the interval narrowing and
// renormalization. Every accepted event is compared with the oldest
// outstanding prediction.
// ----------------------------------------------------------------------------
module interval_event_checker
  import acu_pkg::*;
#(
  parameter int PRECISION = 32,
  parameter int FREQ_BITS = 16
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  input  wire logic     in_stall,
  input  wire acu_in_t  in_item,
  input  wire logic     out_valid,
  input  wire logic     out_stall,
  input  wire acu_out_t out_item,
  output int            fail_count,
  output int            pending
);

  localparam logic KIND_SHIFT     = 1'b0;
  localparam logic KIND_UNDERFLOW = 1'b1;

  localparam logic [63:0] WHOLE     = 64'd1 << PRECISION;
  localparam logic [63:0] SPAN_MASK = WHOLE - 64'd1;
  localparam logic [63:0] HALF      = WHOLE >> 1;
  localparam logic [63:0] QUARTER   = WHOLE >> 2;
  localparam logic [63:0] TOTAL_CAP = 64'd1 << FREQ_BITS;

  logic [63:0] iv_low;
  logic [63:0] iv_high;
  acu_out_t    event_fifo[$];
  int          errs = 0;

  // exact floor(a * span / t) without a wide product
  function automatic logic [63:0] scaled_bound(input logic [63:0] a, input logic [63:0] span,
                                               input logic [63:0] t);
    return a * (span / t) + (a * (span % t)) / t;
  endfunction

  always @(posedge clk) begin : watch
    logic [63:0] t, hi, lo, low, high, span, nl, nh;
    acu_out_t    want, ev;
    acu_out_t    burst[$];
    int          n;
    if (rst) begin
      iv_low  = '0;
      iv_high = SPAN_MASK;
      event_fifo.delete();
    end else begin
      // events of earlier symbols come first, so compare before predicting
      if (out_valid && !out_stall) begin
        if (event_fifo.size() == 0) begin
          $error("event with none expected: kind %0d bit_res %0d last %0d",
                 out_item.kind, out_item.bit_res, out_item.last);
          errs++;
        end else begin
          want = event_fifo.pop_front();
          if (out_item.kind !== want.kind) begin
            $error("kind mismatch: expected %0d, actual %0d", want.kind, out_item.kind);
            errs++;
          end
          if (out_item.bit_res !== want.bit_res) begin
            $error("bit_res mismatch: expected %0d, actual %0d", want.bit_res, out_item.bit_res);
            errs++;
          end
          if (out_item.last !== want.last) begin
            $error("last mismatch: expected %0d, actual %0d", want.last, out_item.last);
            errs++;
          end
        end
      end

      if (in_valid && !in_stall) begin
        t  = 64'(in_item.total);
        hi = 64'(in_item.sym_high);
        lo = 64'(in_item.sym_low);
        if (t == 0) t = 64'd1;
        if (t > TOTAL_CAP) t = TOTAL_CAP;
        if (hi > t) hi = t;
        if (hi == 0) hi = 64'd1;
        if (lo >= hi) lo = hi - 64'd1;

        low  = iv_low & SPAN_MASK;
        high = iv_high & SPAN_MASK;
        if (high < low) high = low;
        span = high - low + 64'd1;

        nl = low + scaled_bound(lo, span, t);
        nh = low + scaled_bound(hi, span, t);
        // collapsed interval keeps a single point
        if (nh <= nl) nh = nl;
        else nh = nh - 64'd1;
        low  = nl & SPAN_MASK;
        high = nh & SPAN_MASK;

        burst.delete();
        n = 0;
        while (((low ^ high) & HALF) == 0) begin
          if (n < MAX_EVENTS) begin
            ev.kind    = KIND_SHIFT;
            ev.bit_res = (low & HALF) != 0;
            ev.last    = 1'b0;
            burst.push_back(ev);
            n++;
          end
          low  = (low << 1) & SPAN_MASK;
          high = ((high << 1) & SPAN_MASK) | 64'd1;
        end
        while ((low & ~high & QUARTER) != 0) begin
          if (n < MAX_EVENTS) begin
            ev.kind    = KIND_UNDERFLOW;
            ev.bit_res = 1'b0;
            ev.last    = 1'b0;
            burst.push_back(ev);
            n++;
          end
          low  = ((low << 1) ^ HALF) & SPAN_MASK;
          high = ((((high ^ HALF) << 1) | HALF) & SPAN_MASK) | 64'd1;
        end
        iv_low  = low;
        iv_high = high;

        for (int i = 0; i < burst.size(); i++) begin
          ev = burst[i];
          if (i == burst.size() - 1) ev.last = 1'b1;
          event_fifo.push_back(ev);
        end
      end
    end
    fail_count <= errs;
    pending    <= event_fifo.size();
  end

endmodule

@@ tb/sv/tb_arithmetic_coder_interval_update.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_arithmetic_coder_interval_update
// Drives symbols into the interval update block: a directed set of corner
// symbols, then random symbols under three idling patterns, including a long
// receiver hold that backs the block up. A checker beside the block predicts
// and compares every event; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_arithmetic_coder_interval_update;
  import acu_pkg::*;

  localparam int PRECISION   = 32;
  localparam int FREQ_BITS   = 16;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_TAIL  = 120;
  localparam int STALL_LIMIT = 4000;
  localparam int N_CORNER    = 20;

  logic     clk       = 1'b0;
  logic     rst       = 1'b1;
  logic     in_valid  = 1'b0;
  logic     in_stall;
  acu_in_t  in_item   = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  acu_out_t out_item;

  int fail_count;
  int pending;
  int tx_idle_pct = 29;
  int rx_idle_pct = 74;
  int hold_asks   = 0;
  int hold_served = 0;
  int hold_left   = 0;
  int quiet_cycles = 0;

  acu_in_t corner_syms [0:N_CORNER-1];

  always #5 clk = ~clk;

  arithmetic_coder_interval_update #(
    .PRECISION(PRECISION),
    .FREQ_BITS(FREQ_BITS)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

  interval_event_checker #(
    .PRECISION(PRECISION),
    .FREQ_BITS(FREQ_BITS)
  ) u_checker (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .fail_count(fail_count),
    .pending   (pending)
  );

  // receiver: random stalls, or a long hold when one is asked for
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_served != hold_asks) begin
      out_stall   <= 1'b1;
      hold_left   <= HOLD_CYCLES - 1;
      hold_served <= hold_served + 1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  // watchdog on cycles with no item moving on either channel
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic offer_symbol(input acu_in_t sym);
    int gap;
    gap = 0;
    while ($urandom_range(99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= sym;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic offer_random(input int count);
    acu_in_t     sym;
    int unsigned tot;
    int unsigned pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < 15) begin
        // noise: any bit pattern, clamping paths included
        sym.sym_low  = 16'($urandom_range(65535));
        sym.sym_high = 17'($urandom_range(131071));
        sym.total    = 17'($urandom_range(131071));
      end else if (pick < 30) begin
        // one-count symbol in a full table: long shift runs
        sym.total    = 17'd65536;
        sym.sym_low  = 16'($urandom_range(65535));
        sym.sym_high = sym.sym_low + 17'd1;
      end else begin
        case ($urandom_range(2))
          0:       tot = $urandom_range(16, 1);
          1:       tot = 65536;
          default: tot = $urandom_range(65536, 1);
        endcase
        sym.total    = 17'(tot);
        sym.sym_high = 17'($urandom_range(tot, 1));
        sym.sym_low  = 16'($urandom_range(sym.sym_high - 1, 0));
      end
      offer_symbol(sym);
    end
  endtask

  initial begin
    corner_syms[0]  = {16'd0,     17'd1,       17'd1};       // whole interval, no events
    corner_syms[1]  = {16'd0,     17'd65536,   17'd65536};   // full table, no events
    corner_syms[2]  = {16'd65535, 17'd65536,   17'd65536};   // top sliver, ones shifted
    corner_syms[3]  = {16'd0,     17'd1,       17'd65536};   // bottom sliver, zeros shifted
    corner_syms[4]  = {16'd1,     17'd3,       17'd4};       // straddles middle: underflow
    corner_syms[5]  = {16'd0,     17'd0,       17'd0};       // zero total and zero upper bound
    corner_syms[6]  = {16'd5,     17'd100,     17'h1FFFF};   // total saturates
    corner_syms[7]  = {16'd0,     17'd3,       17'h10001};   // just above table limit
    corner_syms[8]  = {16'd2,     17'd1000,    17'd10};      // upper bound past total
    corner_syms[9]  = {16'd0,     17'd0,       17'd50};      // upper bound zero
    corner_syms[10] = {16'd65535, 17'd3,       17'd10};      // lower bound past upper
    corner_syms[11] = {16'd7,     17'd7,       17'd7};       // empty symbol
    corner_syms[12] = {16'hFFFF,  17'h1FFFF,   17'h1FFFF};   // all ones
    corner_syms[13] = {16'h0000,  17'h00000,   17'h1FFFF};
    corner_syms[14] = {16'd32767, 17'd32769,   17'd65536};   // narrow around the middle
    corner_syms[15] = {16'd1,     17'd2,       17'd3};
    corner_syms[16] = {16'hAAAA,  17'h0AAAB,   17'h15555};
    corner_syms[17] = {16'h5555,  17'h15555,   17'h10000};
    corner_syms[18] = {16'd16383, 17'd49153,   17'd65536};   // middle half
    corner_syms[19] = {16'd0,     17'd32768,   17'd65536};   // lower half

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // sender light, receiver heavy
    foreach (corner_syms[i]) offer_symbol(corner_syms[i]);
    offer_random(130);

    // sender heavy, receiver light
    tx_idle_pct <= 74;
    rx_idle_pct <= 29;
    offer_random(120);

    // no idling; a long receiver hold first so the block backs up
    tx_idle_pct <= 0;
    rx_idle_pct <= 0;
    hold_asks   <= hold_asks + 1;
    offer_random(110);

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_TAIL) @(posedge clk);

    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
